@@ sv/pwmlsel_pkg.sv @@
// Shared types and constants for the power level selector with battery lockout.
`default_nettype none

package pwmlsel_pkg;

	// Register index codes (byte address is 4 * index)
	localparam logic [2:0] REG_UNDERVOLT  = 3'd0;
	localparam logic [2:0] REG_RECOVER    = 3'd1;
	localparam logic [2:0] REG_DUTY_STEP  = 3'd2;
	localparam logic [2:0] REG_LONG_PRESS = 3'd3;
	localparam logic [2:0] REG_MAX_LEVEL  = 3'd4;
	localparam logic [2:0] REG_PAUSE      = 3'd5;
	localparam logic [2:0] REG_FULL_SCALE = 3'd6;

	// Register reset values
	localparam logic [9:0]  RST_UNDERVOLT  = 10'd340;
	localparam logic [9:0]  RST_RECOVER    = 10'd370;
	localparam logic [11:0] RST_DUTY_STEP  = 12'd595;
	localparam logic [4:0]  RST_LONG_PRESS = 5'd20;
	localparam logic [3:0]  RST_MAX_LEVEL  = 4'd4;
	localparam logic [4:0]  RST_PAUSE      = 5'd5;
	localparam logic [9:0]  RST_FULL_SCALE = 10'd657;

	// Fixed constants
	localparam logic [14:0] DUTY_LIMIT   = 15'd32000;
	localparam logic [3:0]  LOCK_CODE    = 4'd10;
	localparam logic [6:0]  PAUSE_BASE   = 7'd100;
	localparam logic [11:0] ADC_MAX_CODE = 12'd4095;

	typedef struct packed {
		logic [9:0]  undervolt_level;
		logic [9:0]  recover_level;
		logic [11:0] duty_per_level;
		logic [4:0]  long_press_ticks;
		logic [3:0]  max_level;
		logic [4:0]  pause_ticks;
		logic [9:0]  adc_full_scale;
	} cfg_t;

	typedef struct packed {
		logic [3:0] power_level;
		logic       up_held;
		logic       down_held;
		logic [4:0] hold_count;
		logic       long_press_seen;
		logic [6:0] flash_count;
		logic       led_level;
		logic       charge_level;
		logic       in_lockout;
	} state_t;

	typedef struct packed {
		logic [14:0] duty;
		logic        led_on;
		logic        charge_enable;
		logic        lockout;
		logic [3:0]  level;
	} result_t;

endpackage

`default_nettype wire

@@ sv/pwmlsel_ifs.sv @@
// Stream channel interfaces for the tick input and the result output.
`default_nettype none

interface pwmlsel_in_if;
	logic        valid;
	logic        ready;
	logic        up_pin_high;
	logic        down_pin_high;
	logic [11:0] adc_sample;

	modport source (output valid, output up_pin_high, output down_pin_high,
		output adc_sample, input ready);
	modport sink (input valid, input up_pin_high, input down_pin_high,
		input adc_sample, output ready);
endinterface

interface pwmlsel_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] duty;
	logic        led_on;
	logic        charge_enable;
	logic        lockout;
	logic [3:0]  level;

	modport source (output valid, output duty, output led_on, output charge_enable,
		output lockout, output level, input ready);
	modport sink (input valid, input duty, input led_on, input charge_enable,
		input lockout, input level, output ready);
endinterface

`default_nettype wire

@@ sv/pwm_level_selector_with_battery_lockout.sv @@
// Power level selector with battery lockout: one beat per cycle unless the result stalls.
// Datapath: an accepted beat is held in the input register, and its result is loaded into the result register.
// Throughput: one beat per cycle; input register then result register, no stalls
// unless the result register is full and the sink holds off ready.
// Reset (arst_n low): all tick state clears to 0, registers load their defaults,
// both pipeline stages empty.
`default_nettype none

module pwm_level_selector_with_battery_lockout (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	pwmlsel_in_if.sink       item,
	pwmlsel_out_if.source    result
);

	pwmlsel_pkg::cfg_t    cfg;
	pwmlsel_pkg::state_t  state_q;
	pwmlsel_pkg::state_t  state_nxt;
	pwmlsel_pkg::result_t res_nxt;
	pwmlsel_pkg::result_t res_q;

	logic        valid_s1;
	logic        up_s1;
	logic        down_s1;
	logic [11:0] adc_s1;
	logic        out_valid_q;
	logic        advance;
	logic        in_take;

	pwmlsel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pwmlsel_step u_step (
		.cfg           (cfg),
		.cur           (state_q),
		.up_pin_high   (up_s1),
		.down_pin_high (down_s1),
		.adc_sample    (adc_s1),
		.nxt           (state_nxt),
		.res           (res_nxt)
	);

	// Handshake
	assign advance    = valid_s1 & (~out_valid_q | result.ready);
	assign item.ready = ~valid_s1 | advance;
	assign in_take    = item.valid & item.ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			up_s1   <= item.up_pin_high;
			down_s1 <= item.down_pin_high;
			adc_s1  <= item.adc_sample;
		end
	end

	// Tick state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.duty          = res_q.duty;
	assign result.led_on        = res_q.led_on;
	assign result.charge_enable = res_q.charge_enable;
	assign result.lockout       = res_q.lockout;
	assign result.level         = res_q.level;

endmodule

`default_nettype wire

@@ sv/pwmlsel_cfg.sv @@
// APB configuration register file.
`default_nettype none

module pwmlsel_cfg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [4:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output pwmlsel_pkg::cfg_t      cfg
);

	pwmlsel_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.undervolt_level  <= pwmlsel_pkg::RST_UNDERVOLT;
			cfg_q.recover_level    <= pwmlsel_pkg::RST_RECOVER;
			cfg_q.duty_per_level   <= pwmlsel_pkg::RST_DUTY_STEP;
			cfg_q.long_press_ticks <= pwmlsel_pkg::RST_LONG_PRESS;
			cfg_q.max_level        <= pwmlsel_pkg::RST_MAX_LEVEL;
			cfg_q.pause_ticks      <= pwmlsel_pkg::RST_PAUSE;
			cfg_q.adc_full_scale   <= pwmlsel_pkg::RST_FULL_SCALE;
		end else if (wr_en) begin
			case (idx)
				pwmlsel_pkg::REG_UNDERVOLT:  cfg_q.undervolt_level  <= pwdata[9:0];
				pwmlsel_pkg::REG_RECOVER:    cfg_q.recover_level    <= pwdata[9:0];
				pwmlsel_pkg::REG_DUTY_STEP:  cfg_q.duty_per_level   <= pwdata[11:0];
				pwmlsel_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= pwdata[4:0];
				pwmlsel_pkg::REG_MAX_LEVEL:  cfg_q.max_level        <= pwdata[3:0];
				pwmlsel_pkg::REG_PAUSE:      cfg_q.pause_ticks      <= pwdata[4:0];
				pwmlsel_pkg::REG_FULL_SCALE: cfg_q.adc_full_scale   <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = 32'd0;
		case (idx)
			pwmlsel_pkg::REG_UNDERVOLT:  prdata = {22'd0, cfg_q.undervolt_level};
			pwmlsel_pkg::REG_RECOVER:    prdata = {22'd0, cfg_q.recover_level};
			pwmlsel_pkg::REG_DUTY_STEP:  prdata = {20'd0, cfg_q.duty_per_level};
			pwmlsel_pkg::REG_LONG_PRESS: prdata = {27'd0, cfg_q.long_press_ticks};
			pwmlsel_pkg::REG_MAX_LEVEL:  prdata = {28'd0, cfg_q.max_level};
			pwmlsel_pkg::REG_PAUSE:      prdata = {27'd0, cfg_q.pause_ticks};
			pwmlsel_pkg::REG_FULL_SCALE: prdata = {22'd0, cfg_q.adc_full_scale};
			default:                     prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/pwmlsel_step.sv @@
// Per-tick next-state and result logic: buttons, voltage, lockout, duty, LED code.
`default_nettype none

module pwmlsel_step (
	input  wire pwmlsel_pkg::cfg_t   cfg,
	input  wire pwmlsel_pkg::state_t cur,
	input  wire logic                up_pin_high,
	input  wire logic                down_pin_high,
	input  wire logic [11:0]         adc_sample,
	output pwmlsel_pkg::state_t      nxt,
	output pwmlsel_pkg::result_t     res
);

	logic        up_pressed;
	logic        down_pressed;
	logic [5:0]  hold_inc;
	logic [3:0]  lvl_btn;
	logic [21:0] prod;
	logic [9:0]  q0;
	logic [12:0] rem;
	logic [9:0]  volt;
	logic        lock_n;
	logic        lock_exit;
	logic [3:0]  lvl_fin;
	logic [15:0] duty_raw;
	logic [14:0] duty;
	logic [7:0]  flash_inc;
	logic [7:0]  pause_end;
	logic [6:0]  flash_run;

	assign up_pressed   = ~up_pin_high;
	assign down_pressed = ~down_pin_high;
	assign hold_inc     = {1'b0, cur.hold_count} + 6'd1;

	// Battery voltage: sample * full_scale / 4095, one correction step
	assign prod = {10'd0, adc_sample} * {12'd0, cfg.adc_full_scale};
	assign q0   = prod[21:12];
	assign rem  = {1'b0, prod[11:0]} + {3'd0, q0};
	assign volt = q0 + {9'd0, (rem >= {1'b0, pwmlsel_pkg::ADC_MAX_CODE})};

	// Duty from the button-updated level, saturated
	assign duty_raw = {12'd0, lvl_btn} * {4'd0, cfg.duty_per_level};
	assign duty = (duty_raw > {1'b0, pwmlsel_pkg::DUTY_LIMIT}) ?
		pwmlsel_pkg::DUTY_LIMIT : duty_raw[14:0];

	assign flash_inc = {1'b0, cur.flash_count} + 8'd1;
	assign pause_end = {1'b0, pwmlsel_pkg::PAUSE_BASE} + {3'd0, cfg.pause_ticks};
	assign flash_run = flash_inc[6:0];

	always_comb begin
		nxt = cur;

		// Up button
		if (!cur.up_held) begin
			if (up_pressed) begin
				nxt.up_held    = 1'b1;
				nxt.hold_count = 5'd0;
			end
		end else if (!up_pressed) begin
			nxt.up_held = 1'b0;
			if (cur.long_press_seen) begin
				nxt.long_press_seen = 1'b0;
			end else begin
				nxt.power_level = (cur.power_level < cfg.max_level) ?
					cur.power_level + 4'd1 : cfg.max_level;
			end
		end else if (hold_inc > {1'b0, cfg.long_press_ticks}) begin
			nxt.hold_count      = 5'd0;
			nxt.long_press_seen = 1'b1;
			nxt.charge_level    = ~cur.charge_level;
		end else begin
			nxt.hold_count = hold_inc[4:0];
		end

		// Down button
		if (!cur.down_held) begin
			if (down_pressed) begin
				nxt.down_held = 1'b1;
				if (nxt.power_level != 4'd0) begin
					nxt.power_level = nxt.power_level - 4'd1;
				end
			end
		end else if (!down_pressed) begin
			nxt.down_held = 1'b0;
		end
		lvl_btn = nxt.power_level;

		// Lockout; zero voltage leaves it alone
		lock_n    = cur.in_lockout;
		lock_exit = 1'b0;
		if (volt != 10'd0) begin
			if (!cur.in_lockout && (volt < cfg.undervolt_level)) begin
				lock_n = 1'b1;
			end else if (cur.in_lockout && (volt > cfg.recover_level)) begin
				lock_n    = 1'b0;
				lock_exit = 1'b1;
			end
		end
		nxt.in_lockout = lock_n;

		if (lock_n) begin
			lvl_fin = pwmlsel_pkg::LOCK_CODE;
		end else if (lock_exit) begin
			lvl_fin = 4'd0;
		end else begin
			lvl_fin = lvl_btn;
		end
		nxt.power_level = lvl_fin;

		// LED blink code
		if (lvl_fin == 4'd0) begin
			nxt.flash_count = 7'd0;
			nxt.led_level   = 1'b0;
		end else if (cur.flash_count >= pwmlsel_pkg::PAUSE_BASE) begin
			nxt.flash_count = (flash_inc > pause_end) ? 7'd0 : flash_run;
		end else begin
			nxt.led_level   = ~cur.led_level;
			nxt.flash_count = (flash_run >= {2'd0, lvl_fin, 1'b0}) ?
				pwmlsel_pkg::PAUSE_BASE : flash_run;
		end

		res.duty          = (lock_n || lock_exit) ? 15'd0 : duty;
		res.led_on        = nxt.led_level;
		res.charge_enable = nxt.charge_level;
		res.lockout       = lock_n;
		res.level         = lvl_fin;
	end

endmodule

`default_nettype wire
